// File: hdl/mrr_pkg.sv
package mrr_pkg;

	localparam int NUM_WIDTH  = 63;
	localparam int RAND_WIDTH = 31;
	localparam int SHIFT_W    = $clog2(NUM_WIDTH + 1);
	localparam int RCNT_W     = $clog2(RAND_WIDTH + 1);
	localparam int IN_W       = ((NUM_WIDTH + RAND_WIDTH + 7) / 8) * 8;
	localparam int OUT_W      = 8;

	typedef logic [NUM_WIDTH-1:0] num_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_DECOMP,
		ST_REDUCE,
		ST_EXP_BIT,
		ST_MUL_ACC,
		ST_MUL_BASE,
		ST_CHECK,
		ST_SQR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_ACC_BASE,
		OP_BASE_BASE,
		OP_ACC_ACC,
		OP_RES_RES
	} mul_op_t;

	// start / finish strobes of a serial unit
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

endpackage

// File: hdl/mrr_modmul.sv
module mrr_modmul (
	input  logic              clk,
	input  logic              arst_n,
	input  mrr_pkg::unit_req_t req,
	output mrr_pkg::unit_rsp_t rsp,
	input  mrr_pkg::num_t     op_a,
	input  mrr_pkg::num_t     op_b,
	input  mrr_pkg::num_t     modulus,
	output mrr_pkg::num_t     product
);
	import mrr_pkg::*;

	logic             busy_q;
	logic             done_q;
	num_t             acc_q;
	num_t             a_q;
	num_t             b_q;
	num_t             m_q;
	logic [NUM_WIDTH:0] acc_sum;
	logic [NUM_WIDTH:0] a_dbl;
	num_t             acc_nxt;
	num_t             a_nxt;

	// one multiplier bit per cycle: add when the bit is set, double the addend
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, a_q};
		if (acc_sum >= {1'b0, m_q}) begin
			acc_sum = acc_sum - {1'b0, m_q};
		end
		acc_nxt = b_q[0] ? acc_sum[NUM_WIDTH-1:0] : acc_q;
		a_dbl = {a_q, 1'b0};
		if (a_dbl >= {1'b0, m_q}) begin
			a_dbl = a_dbl - {1'b0, m_q};
		end
		a_nxt = a_dbl[NUM_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= op_a;
			b_q   <= op_b;
			m_q   <= modulus;
		end else if (busy_q && b_q != '0) begin
			acc_q <= acc_nxt;
			a_q   <= a_nxt;
			b_q   <= b_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign product  = acc_q;

endmodule

// File: hdl/mrr_modred.sv
module mrr_modred (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mrr_pkg::unit_req_t              req,
	output mrr_pkg::unit_rsp_t              rsp,
	input  logic [mrr_pkg::RAND_WIDTH-1:0]  dividend,
	input  mrr_pkg::num_t                   modulus,
	output mrr_pkg::num_t                   remainder
);
	import mrr_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [RCNT_W-1:0]     cnt_q;
	logic [RAND_WIDTH-1:0] r_q;
	num_t                  rem_q;
	num_t                  m_q;
	logic [NUM_WIDTH:0]    trial;

	// restoring remainder, dividend bits taken msb first
	always_comb begin
		trial = {rem_q, r_q[RAND_WIDTH-1]};
		if (trial >= {1'b0, m_q}) begin
			trial = trial - {1'b0, m_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= RCNT_W'(RAND_WIDTH);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			r_q   <= dividend;
			m_q   <= modulus;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= trial[NUM_WIDTH-1:0];
			r_q   <= r_q << 1;
		end
	end

	assign rsp.busy  = busy_q;
	assign rsp.done  = done_q;
	assign remainder = rem_q;

endmodule

// File: hdl/miller_rabin_round.sv
// One Miller-Rabin round per item.
// Input stream s_axis_*: tdata carries the candidate n (bits 62:0) and the
// random word r (bits 93:63). Output stream m_axis_*: tdata bit 0 verdict
// (1 = prime or passes), bit 1 settled (1 = verdict final).
// n below 2, n of 2 or 3 and even n go from classification straight to the
// done state. An odd n runs: factor-of-two strip of n-1, r mod (n-3)
// bit-serially, then square-and-multiply over the bits of d with a
// double-and-add modular multiplier that takes one multiplier bit per cycle,
// then up to s-1 further squarings. The multiplier sets the rate.
// One item is in work at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new item is accepted while a
// result waits; a stalled receiver holds m_axis_tvalid and tdata, and a
// second finished result waits inside until the register frees.
// arst_n clears the control state; the block comes out idle and empty.
module miller_rabin_round (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [mrr_pkg::IN_W-1:0]  s_axis_tdata,  // candidate, random_word, zero pad
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [mrr_pkg::OUT_W-1:0] m_axis_tdata   // verdict, settled, zero pad
);
	import mrr_pkg::*;

	state_t                state_q, state_d;
	num_t                  n_q;
	num_t                  nm1_q;
	num_t                  nm3_q;
	logic [RAND_WIDTH-1:0] r_q;
	num_t                  d_q;
	num_t                  e_q;
	num_t                  acc_q;
	num_t                  base_q;
	logic [SHIFT_W-1:0]    s_q;
	logic                  verdict_q;
	logic                  settled_q;
	logic                  out_valid_q;
	logic                  out_verdict_q;
	logic                  out_settled_q;

	unit_req_t mul_req, red_req;
	unit_rsp_t mul_rsp, red_rsp;
	mul_op_t   mul_op;
	num_t      mul_a, mul_b, mul_res, red_rem;
	logic      e_more;
	logic      out_free;

	assign e_more   = |e_q[NUM_WIDTH-1:1];
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		unique case (mul_op)
			OP_ACC_BASE:  begin mul_a = acc_q;   mul_b = base_q;  end
			OP_BASE_BASE: begin mul_a = base_q;  mul_b = base_q;  end
			OP_ACC_ACC:   begin mul_a = acc_q;   mul_b = acc_q;   end
			OP_RES_RES:   begin mul_a = mul_res; mul_b = mul_res; end
			default:      begin mul_a = acc_q;   mul_b = base_q;  end
		endcase
	end

	mrr_modmul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.rsp     (mul_rsp),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.modulus (n_q),
		.product (mul_res)
	);

	mrr_modred u_red (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (red_req),
		.rsp       (red_rsp),
		.dividend  (r_q),
		.modulus   (nm3_q),
		.remainder (red_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		red_req.start = 1'b0;
		mul_op        = OP_ACC_BASE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				if (n_q < NUM_WIDTH'(4) || !n_q[0]) state_d = ST_DONE;
				else state_d = ST_DECOMP;
			end
			ST_DECOMP: begin
				if (d_q[0]) begin
					red_req.start = 1'b1;
					state_d       = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_rsp.done) state_d = ST_EXP_BIT;
			end
			ST_EXP_BIT: begin
				if (e_q == '0) begin
					state_d = ST_CHECK;
				end else if (e_q[0]) begin
					mul_req.start = 1'b1;
					mul_op        = OP_ACC_BASE;
					state_d       = ST_MUL_ACC;
				end else begin
					mul_req.start = 1'b1;
					mul_op        = OP_BASE_BASE;
					state_d       = ST_MUL_BASE;
				end
			end
			ST_MUL_ACC: begin
				if (mul_rsp.done) begin
					if (e_more) begin
						mul_req.start = 1'b1;
						mul_op        = OP_BASE_BASE;
						state_d       = ST_MUL_BASE;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_MUL_BASE: begin
				if (mul_rsp.done) state_d = ST_EXP_BIT;
			end
			ST_CHECK: begin
				if (acc_q == NUM_WIDTH'(1) || acc_q == nm1_q || s_q == SHIFT_W'(1)) begin
					state_d = ST_DONE;
				end else begin
					mul_req.start = 1'b1;
					mul_op        = OP_ACC_ACC;
					state_d       = ST_SQR;
				end
			end
			ST_SQR: begin
				if (mul_rsp.done) begin
					if (mul_res == nm1_q || s_q == SHIFT_W'(1)) begin
						state_d = ST_DONE;
					end else begin
						mul_req.start = 1'b1;
						mul_op        = OP_RES_RES;
					end
				end
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					n_q <= s_axis_tdata[NUM_WIDTH-1:0];
					r_q <= s_axis_tdata[NUM_WIDTH +: RAND_WIDTH];
				end
			end
			ST_CLASSIFY: begin
				d_q   <= n_q - 1'b1;
				nm1_q <= n_q - 1'b1;
				nm3_q <= n_q - NUM_WIDTH'(3);
				s_q   <= '0;
				if (n_q < NUM_WIDTH'(2)) begin
					verdict_q <= 1'b0;
					settled_q <= 1'b1;
				end else if (n_q < NUM_WIDTH'(4)) begin
					verdict_q <= 1'b1;
					settled_q <= 1'b1;
				end else begin
					verdict_q <= 1'b0;
					settled_q <= 1'b1;
				end
			end
			ST_DECOMP: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					s_q <= s_q + 1'b1;
				end
			end
			ST_REDUCE: begin
				if (red_rsp.done) begin
					base_q <= red_rem + NUM_WIDTH'(2);
					acc_q  <= NUM_WIDTH'(1);
					e_q    <= d_q;
				end
			end
			ST_MUL_ACC: begin
				if (mul_rsp.done) acc_q <= mul_res;
			end
			ST_MUL_BASE: begin
				if (mul_rsp.done) begin
					base_q <= mul_res;
					e_q    <= e_q >> 1;
				end
			end
			ST_CHECK: begin
				if (acc_q == NUM_WIDTH'(1) || acc_q == nm1_q) begin
					verdict_q <= 1'b1;
					settled_q <= 1'b0;
				end else begin
					verdict_q <= 1'b0;
					settled_q <= 1'b1;
					s_q       <= s_q - 1'b1;
				end
			end
			ST_SQR: begin
				if (mul_rsp.done) begin
					acc_q <= mul_res;
					s_q   <= s_q - 1'b1;
					if (mul_res == nm1_q) begin
						verdict_q <= 1'b1;
						settled_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_verdict_q <= verdict_q;
			out_settled_q <= settled_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-2){1'b0}}, out_settled_q, out_verdict_q};

endmodule

// File: hdl/mrr_checker.sv
module mrr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic [mrr_pkg::IN_W-1:0]  s_axis_tdata,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [mrr_pkg::OUT_W-1:0] m_axis_tdata
);
	import mrr_pkg::*;

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// a failing round is always final
	a_fail_settled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[1])
		else $error("composite verdict not settled");

	// one item in work at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input ready right after an item was taken");

	// pad bits above verdict and settled stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:2] == '0)
		else $error("pad bits of result not zero");

endmodule

bind miller_rabin_round mrr_checker u_mrr_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

	import mrr_pkg::*;

	typedef logic [RAND_WIDTH-1:0] rnd_t;

	typedef struct {
		num_t candidate;
		rnd_t rword;
		logic verdict;
		logic settled;
	} round_outcome_t;

	localparam rnd_t R_MAX      = '1;
	localparam num_t N_MAX      = '1;
	localparam int   HOLD_LEN   = 400;
	localparam longint TIMEOUT_NS = 40_000_000;

	// primes and strong pseudoprimes of assorted sizes
	localparam num_t PRIME_POOL [10] = '{
		63'd13, 63'd97, 63'd65537, 63'd2047, 63'd998244353, 63'd1000000007,
		63'd3215031751, 63'd2147483647, 63'd2305843009213693951,
		63'd9223372036854775783
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;  // candidate, random_word, zero pad
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;      // verdict, settled, zero pad

	round_outcome_t pending_outcomes[$];
	int error_count = 0;
	int items_sent = 0;
	int outcomes_checked = 0;
	int passes_seen = 0;
	int unsettled_seen = 0;
	int wide_items = 0;
	int burst_left = 0;
	logic hold_off_req = 1'b0;

	miller_rabin_round u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic num_t mul_mod(num_t x, num_t y, num_t m);
		logic [2*NUM_WIDTH-1:0] prod;
		prod = x * y;
		return num_t'(prod % m);
	endfunction

	function automatic num_t pow_mod(num_t base, num_t e, num_t m);
		num_t acc;
		num_t b;
		acc = 1;
		b = base % m;
		while (e != 0) begin
			if (e[0])
				acc = mul_mod(acc, b, m);
			b = mul_mod(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// strong probable-prime round with witness r mod (n-3) + 2
	function automatic round_outcome_t mr_round_outcome(num_t n, rnd_t r);
		round_outcome_t res;
		num_t nm1;
		num_t d;
		num_t witness;
		num_t x;
		int s;
		int k;
		logic pass;
		res.candidate = n;
		res.rword = r;
		if (n < 2) begin
			res.verdict = 1'b0;
			res.settled = 1'b1;
		end else if (n < 4) begin
			res.verdict = 1'b1;
			res.settled = 1'b1;
		end else if (!n[0]) begin
			res.verdict = 1'b0;
			res.settled = 1'b1;
		end else begin
			nm1 = n - 1;
			d = nm1;
			s = 0;
			while (!d[0]) begin
				d = d >> 1;
				s++;
			end
			witness = num_t'(r % (n - 3)) + 2;
			x = pow_mod(witness, d, n);
			pass = (x == 1) || (x == nm1);
			for (k = 1; k < s && !pass; k++) begin
				x = mul_mod(x, x, n);
				if (x == nm1)
					pass = 1'b1;
			end
			res.verdict = pass;
			res.settled = !pass;
		end
		return res;
	endfunction

	task automatic send_item(input num_t n, input rnd_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= {$urandom(), $urandom(), $urandom()};
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_W - NUM_WIDTH - RAND_WIDTH){1'b0}}, r, n};
		do @(posedge clk); while (!s_axis_tready);
		pending_outcomes.push_back(mr_round_outcome(n, r));
		burst_left--;
		items_sent++;
	endtask

	// receiver: stall pattern is redrawn at random from four modes; a toggle of
	// hold_off_req starts a long hold-off
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_count = 0;
	logic hold_seen = 1'b0;
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 128 == 0)
			rx_mode <= $urandom_range(0, 3);
		if (hold_off_req != hold_seen) begin
			hold_seen <= hold_off_req;
			hold_count <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (hold_count > 0) begin
			hold_count <= hold_count - 1;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (rx_cycle % 4 == 0);
				default: m_axis_tready <= (rx_cycle % 8 == 3);
			endcase
		end
	end

	always @(posedge clk) begin
		round_outcome_t exp_o;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected output item, tdata=%h", $time, m_axis_tdata);
				error_count++;
			end else begin
				exp_o = pending_outcomes.pop_front();
				outcomes_checked++;
				if (exp_o.verdict)
					passes_seen++;
				if (!exp_o.settled)
					unsettled_seen++;
				if (m_axis_tdata[0] !== exp_o.verdict) begin
					$display("%0t: verdict n=%0d r=%0d expected %0b got %0b", $time,
						exp_o.candidate, exp_o.rword, exp_o.verdict, m_axis_tdata[0]);
					error_count++;
				end
				if (m_axis_tdata[1] !== exp_o.settled) begin
					$display("%0t: settled n=%0d r=%0d expected %0b got %0b", $time,
						exp_o.candidate, exp_o.rword, exp_o.settled, m_axis_tdata[1]);
					error_count++;
				end
			end
		end
	end

	task automatic test_trivial_classes();
		send_item(0, 0);
		send_item(1, R_MAX);
		send_item(2, 0);
		send_item(3, R_MAX);
		send_item(4, 0);
		send_item(6, R_MAX);
		send_item(N_MAX - 1, R_MAX);
	endtask

	task automatic test_odd_directed();
		send_item(5, 0);      // passes only through a squaring
		send_item(5, R_MAX);
		send_item(7, 0);      // x lands on 1
		send_item(7, 1);      // x lands on n-1, no squarings
		send_item(9, 0);
		send_item(561, 0);    // Carmichael number
		send_item(2047, 0);   // strong pseudoprime to base 2
		send_item(63'd3215031751, 0);
		send_item(65537, R_MAX);
		send_item(63'd998244353, 12345);
		send_item(63'd2305843009213693951, R_MAX);
		send_item(63'd9223372036854775783, 0);
		send_item(N_MAX, 0);
		send_item(N_MAX, R_MAX);
		wide_items += 4;
	endtask

	// output held off long enough that the block backs up into its input
	task automatic test_output_hold_off();
		hold_off_req = ~hold_off_req;
		for (int i = 0; i < 6; i++)
			send_item(num_t'($urandom_range(0, 40)), rnd_t'($urandom()));
	endtask

	task automatic test_random_rounds(input int count);
		num_t n;
		rnd_t r;
		int w;
		for (int i = 0; i < count; i++) begin
			r = rnd_t'($urandom());
			case ($urandom_range(0, 7))
				0: r = '0;
				1: r = R_MAX;
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: n = num_t'($urandom_range(0, 15));
				1: begin
					w = $urandom_range(3, NUM_WIDTH);
					n = num_t'({$urandom(), $urandom()}) & ((num_t'(1) << w) - 1);
					n[0] = 1'b0;
				end
				2: begin
					n = num_t'({$urandom(), $urandom()});
					n[NUM_WIDTH-1] = 1'b1;
					n[0] = 1'b1;
					wide_items++;
				end
				3: n = PRIME_POOL[$urandom_range(0, 9)];
				default: begin
					w = $urandom_range(4, 24);
					n = num_t'({$urandom(), $urandom()}) & ((num_t'(1) << w) - 1);
					n[w-1] = 1'b1;
					n[0] = 1'b1;
				end
			endcase
			send_item(n, r);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_trivial_classes();
		test_odd_directed();
		test_output_hold_off();
		test_random_rounds(73);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		// any stray result shows up here
		repeat (200) @(posedge clk);
		$display("covered %0d candidates (%0d near full width), %0d results checked",
			items_sent, wide_items, outcomes_checked);
		$display("%0d rounds passed (%0d left open), output hold-off of %0d cycles",
			passes_seen, unsettled_seen, HOLD_LEN);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", pending_outcomes.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/mrr_pkg.sv
hdl/mrr_modmul.sv
hdl/mrr_modred.sv
hdl/miller_rabin_round.sv
hdl/mrr_checker.sv
sim/tb.sv
